// File: src/eott_pkg.sv
// Shared types and codes for the expiring one-shot token table.
`default_nettype none

package eott_pkg;

    localparam logic [15:0] LIFETIME_RESET = 16'd600;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TAKE   = 1'b1;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_FULL      = 3'd1;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [2:0] STAT_EXPIRED   = 3'd3;
    localparam logic [2:0] STAT_MISMATCH  = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_FINISH
    } eott_state_t;

    typedef struct packed {
        logic [63:0] id_high;
        logic [63:0] id_low;
        logic [63:0] owner;
        logic [31:0] key;
        logic [32:0] expiry;
    } entry_t;

    typedef struct packed {
        logic rd_en;
        logic vld_we;
        logic vld_wdata;
        logic ent_we;
    } mem_ctl_t;

endpackage

`default_nettype wire

// File: src/expiring_one_shot_token_table.sv
// Top level of the expiring one-shot token table.
//
// Table of TABLE_SLOTS pending entries (128-bit id, owner tag, key handle, expiry).
// An insert frees expired entries and stores into the lowest free slot with
// expiry = now_time + lifetime_seconds, or reports full. A take frees the lowest
// live entry whose id matches and reports ok with the key, expired, owner mismatch
// or not found, and frees every other expired entry. Each transaction walks the
// slot memory once through one read port, one slot per cycle; in_ready is low from
// acceptance until the result is loaded into the output register, so a new item
// is taken only after the last one is through. After reset a clearing pass over
// all TABLE_SLOTS slots empties the valid memory before the first item is accepted;
// configuration writes are taken at any time.
`default_nettype none

module expiring_one_shot_token_table #(
    parameter int TABLE_SLOTS = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [31:0] now_time,
    input  wire logic [63:0] token_high,
    input  wire logic [63:0] token_low,
    input  wire logic [63:0] owner_tag,
    input  wire logic [31:0] key_handle,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [31:0]      returned_key,
    output logic [63:0]      issued_high,
    output logic [63:0]      issued_low
);
    import eott_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SLOTS);

    logic [15:0]      lifetime_reg;
    mem_ctl_t         mem_ctl;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    entry_t           wr_entry, rd_entry;
    logic             rd_vld;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg <= LIFETIME_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            lifetime_reg <= cfg_data;
        end
    end

    eott_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .lifetime     (lifetime_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .now_time     (now_time),
        .token_high   (token_high),
        .token_low    (token_low),
        .owner_tag    (owner_tag),
        .key_handle   (key_handle),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .returned_key (returned_key),
        .issued_high  (issued_high),
        .issued_low   (issued_low),
        .mem_ctl      (mem_ctl),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .wr_entry     (wr_entry),
        .rd_entry     (rd_entry),
        .rd_vld       (rd_vld)
    );

    eott_mem #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .IDX_W       (IDX_W)
    ) u_mem (
        .clk      (clk),
        .ctl      (mem_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_entry (rd_entry),
        .rd_vld   (rd_vld)
    );

endmodule

`default_nettype wire

// File: src/eott_mem.sv
// Slot storage: entry memory and valid-bit memory, one read and one write port each.
`default_nettype none

module eott_mem #(
    parameter int TABLE_SLOTS = 256,
    parameter int IDX_W = $clog2(TABLE_SLOTS)
) (
    input  wire logic              clk,
    input  wire eott_pkg::mem_ctl_t ctl,
    input  wire logic [IDX_W-1:0]  rd_addr,
    input  wire logic [IDX_W-1:0]  wr_addr,
    input  wire eott_pkg::entry_t  wr_entry,
    output eott_pkg::entry_t       rd_entry,
    output logic                   rd_vld
);
    import eott_pkg::*;

    entry_t entry_mem [TABLE_SLOTS];
    logic   valid_mem [TABLE_SLOTS];

    always_ff @(posedge clk)
    begin
        if (ctl.ent_we)
        begin
            entry_mem[wr_addr] <= wr_entry;
        end
        if (ctl.rd_en)
        begin
            rd_entry <= entry_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.vld_we)
        begin
            valid_mem[wr_addr] <= ctl.vld_wdata;
        end
        if (ctl.rd_en)
        begin
            rd_vld <= valid_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/eott_ctrl.sv
// Sequencer and shared compare unit: walks the slots once per transaction.
`default_nettype none

module eott_ctrl #(
    parameter int TABLE_SLOTS = 256,
    parameter int IDX_W = $clog2(TABLE_SLOTS)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [15:0]       lifetime,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              op,
    input  wire logic [31:0]       now_time,
    input  wire logic [63:0]       token_high,
    input  wire logic [63:0]       token_low,
    input  wire logic [63:0]       owner_tag,
    input  wire logic [31:0]       key_handle,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [2:0]             status,
    output logic [31:0]            returned_key,
    output logic [63:0]            issued_high,
    output logic [63:0]            issued_low,
    output eott_pkg::mem_ctl_t     mem_ctl,
    output logic [IDX_W-1:0]       rd_addr,
    output logic [IDX_W-1:0]       wr_addr,
    output eott_pkg::entry_t       wr_entry,
    input  wire eott_pkg::entry_t  rd_entry,
    input  wire logic              rd_vld
);
    import eott_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    eott_state_t state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             issuing_reg, issuing_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [2:0]       stat_reg, stat_next;
    logic [31:0]      rkey_reg, rkey_next;
    logic             out_valid_reg, out_valid_next;

    logic             op_reg;
    logic [31:0]      now_reg;
    logic [63:0]      idh_reg, idl_reg, owner_reg;
    logic [31:0]      key_reg;
    logic [2:0]       status_reg, status_next;
    logic [31:0]      returned_key_reg, returned_key_next;
    logic [63:0]      issued_high_reg, issued_high_next;
    logic [63:0]      issued_low_reg, issued_low_next;

    logic accept, scan_done, out_free, expired, id_match;

    assign accept    = in_valid && in_ready;
    assign scan_done = !issuing_reg && !pend_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign expired   = rd_entry.expiry <= {1'b0, now_reg};
    assign id_match  = (rd_entry.id_high == idh_reg) && (rd_entry.id_low == idl_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = (op_reg == OP_INSERT && hit_reg) ? ST_WRITE : ST_FINISH;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory control and outputs
    always_comb
    begin
        in_ready          = (state_reg == ST_IDLE);
        cnt_next          = cnt_reg;
        issuing_next      = issuing_reg;
        pend_next         = 1'b0;
        pend_idx_next     = cnt_reg;
        hit_next          = hit_reg;
        hit_idx_next      = hit_idx_reg;
        stat_next         = stat_reg;
        rkey_next         = rkey_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        status_next       = status_reg;
        returned_key_next = returned_key_reg;
        issued_high_next  = issued_high_reg;
        issued_low_next   = issued_low_reg;

        mem_ctl           = '0;
        rd_addr           = cnt_reg;
        wr_addr           = pend_idx_reg;
        wr_entry.id_high  = idh_reg;
        wr_entry.id_low   = idl_reg;
        wr_entry.owner    = owner_reg;
        wr_entry.key      = key_reg;
        wr_entry.expiry   = {1'b0, now_reg} + {17'd0, lifetime};

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_ctl.vld_we = 1'b1;
                wr_addr        = cnt_reg;
                cnt_next       = (cnt_reg == LAST_IDX) ? '0 : cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next     = '0;
                    issuing_next = 1'b1;
                    hit_next     = 1'b0;
                    hit_idx_next = '0;
                    stat_next    = STAT_NOT_FOUND;
                    rkey_next    = '0;
                end
            end
            ST_SCAN:
            begin
                if (issuing_reg)
                begin
                    mem_ctl.rd_en = 1'b1;
                    pend_next     = 1'b1;
                    if (cnt_reg == LAST_IDX)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                if (pend_reg)
                begin
                    if (op_reg == OP_TAKE)
                    begin
                        // First live id match is freed whatever its outcome.
                        if (rd_vld && id_match && !hit_reg)
                        begin
                            hit_next       = 1'b1;
                            mem_ctl.vld_we = 1'b1;
                            if (expired)
                            begin
                                stat_next = STAT_EXPIRED;
                            end
                            else if (rd_entry.owner != owner_reg)
                            begin
                                stat_next = STAT_MISMATCH;
                            end
                            else
                            begin
                                stat_next = STAT_OK;
                                rkey_next = rd_entry.key;
                            end
                        end
                        else if (rd_vld && expired)
                        begin
                            mem_ctl.vld_we = 1'b1;
                        end
                    end
                    else
                    begin
                        if (rd_vld && expired)
                        begin
                            mem_ctl.vld_we = 1'b1;
                        end
                        // Lowest slot that is free once the sweep is applied.
                        if ((!rd_vld || expired) && !hit_reg)
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = pend_idx_reg;
                        end
                    end
                end
            end
            ST_WRITE:
            begin
                mem_ctl.ent_we    = 1'b1;
                mem_ctl.vld_we    = 1'b1;
                mem_ctl.vld_wdata = 1'b1;
                wr_addr           = hit_idx_reg;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (op_reg == OP_INSERT)
                    begin
                        status_next       = hit_reg ? STAT_OK : STAT_FULL;
                        returned_key_next = '0;
                        issued_high_next  = hit_reg ? idh_reg : '0;
                        issued_low_next   = hit_reg ? idl_reg : '0;
                    end
                    else
                    begin
                        status_next       = stat_reg;
                        returned_key_next = rkey_reg;
                        issued_high_next  = '0;
                        issued_low_next   = '0;
                    end
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            issuing_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            issuing_reg   <= issuing_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg     <= pend_idx_next;
        hit_idx_reg      <= hit_idx_next;
        stat_reg         <= stat_next;
        rkey_reg         <= rkey_next;
        status_reg       <= status_next;
        returned_key_reg <= returned_key_next;
        issued_high_reg  <= issued_high_next;
        issued_low_reg   <= issued_low_next;
        if (accept)
        begin
            op_reg    <= op;
            now_reg   <= now_time;
            idh_reg   <= token_high;
            idl_reg   <= token_low;
            owner_reg <= owner_tag;
            key_reg   <= key_handle;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign returned_key = returned_key_reg;
    assign issued_high  = issued_high_reg;
    assign issued_low   = issued_low_reg;

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_SCAN)
        else $error("accepted transaction did not start a scan");

    a_write_needs_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.ent_we |-> (op_reg == OP_INSERT) && hit_reg)
        else $error("entry written without a free slot on insert");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.rd_en && mem_ctl.vld_we) |-> rd_addr != wr_addr)
        else $error("valid write collides with read address");

    a_full_has_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == STAT_FULL) |->
            (issued_high_reg == '0) && (issued_low_reg == '0) && (returned_key_reg == '0))
        else $error("full result carries nonzero fields");

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the expiring one-shot token table: inserts, takes and lifetimes.
module testbench;
    import eott_pkg::*;

    localparam int SLOTS = 256;
    localparam int ITEM_CYCLES = 260;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int HOLD_CYCLES = 1500;
    localparam int RANDOM_PER_SETTING = 120;

    // where a take of a live entry places its time
    localparam int AT_NOW = 0;
    localparam int AT_EXPIRY = 1;
    localparam int JUST_BEFORE = 2;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] key;
        logic [63:0] high;
        logic [63:0] low;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        op = OP_INSERT;
    logic [31:0] now_time = '0;
    logic [63:0] token_high = '0;
    logic [63:0] token_low = '0;
    logic [63:0] owner_tag = '0;
    logic [31:0] key_handle = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [31:0] returned_key;
    logic [63:0] issued_high;
    logic [63:0] issued_low;

    // table contents as the testbench believes them
    logic        tbl_valid [SLOTS];
    logic [63:0] tbl_high [SLOTS];
    logic [63:0] tbl_low [SLOTS];
    logic [63:0] tbl_owner [SLOTS];
    logic [31:0] tbl_key [SLOTS];
    logic [32:0] tbl_expiry [SLOTS];
    logic [15:0] lifetime;

    reply_t      expected_replies [$];
    logic [31:0] wall_time = '0;
    bit          no_idling = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;
    int          error_count = 0;
    int          replies_seen = 0;
    int          n_inserts = 0;
    int          n_takes = 0;
    int          n_cfg = 0;
    int          status_seen [5];

    expiring_one_shot_token_table DUT (.*);

    always #6 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void sweep_expired(logic [31:0] now);
        int s;
        for (s = 0; s < SLOTS; s++)
            if (tbl_valid[s] && tbl_expiry[s] <= {1'b0, now})
                tbl_valid[s] = 1'b0;
    endfunction

    function automatic reply_t predict_table_op(logic kind, logic [31:0] now,
                                                logic [63:0] idh, logic [63:0] idl,
                                                logic [63:0] owner, logic [31:0] key);
        reply_t r;
        int     s;
        bit     done;
        r = '0;
        done = 1'b0;
        if (kind == OP_INSERT) begin
            sweep_expired(now);
            r.status = STAT_FULL;
            for (s = 0; s < SLOTS && !done; s++) begin
                if (!tbl_valid[s]) begin
                    tbl_valid[s] = 1'b1;
                    tbl_high[s] = idh;
                    tbl_low[s] = idl;
                    tbl_owner[s] = owner;
                    tbl_key[s] = key;
                    tbl_expiry[s] = {1'b0, now} + {17'b0, lifetime};
                    r.status = STAT_OK;
                    r.high = idh;
                    r.low = idl;
                    done = 1'b1;
                end
            end
        end else begin
            r.status = STAT_NOT_FOUND;
            for (s = 0; s < SLOTS && !done; s++) begin
                if (tbl_valid[s] && tbl_high[s] == idh && tbl_low[s] == idl) begin
                    if (tbl_expiry[s] <= {1'b0, now}) begin
                        r.status = STAT_EXPIRED;
                    end else if (tbl_owner[s] != owner) begin
                        r.status = STAT_MISMATCH;
                    end else begin
                        r.status = STAT_OK;
                        r.key = tbl_key[s];
                    end
                    tbl_valid[s] = 1'b0;
                    done = 1'b1;
                end
            end
            sweep_expired(now);
        end
        return r;
    endfunction

    // Leaves in_valid high on return so a following item goes out back to back.
    task automatic send_item(logic kind, logic [31:0] now, logic [63:0] idh,
                             logic [63:0] idl, logic [63:0] owner, logic [31:0] key);
        int gap;
        if (!no_idling && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= kind;
        now_time <= now;
        token_high <= idh;
        token_low <= idl;
        owner_tag <= owner;
        key_handle <= key;
        do @(posedge clk); while (!in_ready);
        expected_replies.push_back(predict_table_op(kind, now, idh, idl, owner, key));
        if (kind == OP_INSERT)
            n_inserts++;
        else
            n_takes++;
    endtask

    task automatic wait_drained(int settle);
        in_valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_lifetime(logic [15:0] value);
        wait_drained(4);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        lifetime = value;
        n_cfg++;
    endtask

    // Take a random live entry; fall back to an unknown id if the table is empty.
    task automatic take_live(logic [31:0] now, bit wrong_owner, int when);
        int          live [$];
        int          s;
        int          pick;
        logic [63:0] owner;
        logic [31:0] at;
        for (s = 0; s < SLOTS; s++)
            if (tbl_valid[s])
                live.push_back(s);
        if (live.size() == 0) begin
            send_item(OP_TAKE, now, rand64(), rand64(), rand64(), $urandom);
        end else begin
            pick = live[$urandom_range(0, live.size() - 1)];
            owner = wrong_owner ? rand64() : tbl_owner[pick];
            at = now;
            if (!tbl_expiry[pick][32] && when == AT_EXPIRY)
                at = tbl_expiry[pick][31:0];
            else if (!tbl_expiry[pick][32] && when == JUST_BEFORE)
                at = tbl_expiry[pick][31:0] - 32'd1;
            send_item(OP_TAKE, at, tbl_high[pick], tbl_low[pick], owner, $urandom);
        end
    endtask

    task automatic random_item();
        int          roll;
        int          s;
        logic [63:0] idh;
        logic [63:0] idl;
        roll = $urandom_range(0, 99);
        wall_time = wall_time + $urandom_range(0, lifetime / 8 + 1);
        idh = rand64();
        idl = rand64();
        if (roll < 45) begin
            if (roll < 5) begin
                s = $urandom_range(0, SLOTS - 1);
                if (tbl_valid[s]) begin
                    idh = tbl_high[s];
                    idl = tbl_low[s];
                end
            end
            send_item(OP_INSERT, wall_time, idh, idl, rand64(), $urandom);
        end else if (roll < 85) begin
            take_live(wall_time, roll >= 78,
                      roll < 55 ? AT_EXPIRY : (roll < 62 ? JUST_BEFORE : AT_NOW));
        end else if (roll < 90) begin
            send_item(logic'($urandom_range(0, 1)), $urandom, idh, idl, rand64(), $urandom);
        end else begin
            send_item(OP_TAKE, wall_time, idh, idl, rand64(), $urandom);
        end
    endtask

    task automatic check_reply();
        reply_t want;
        reply_t got;
        got = {status, returned_key, issued_high, issued_low};
        replies_seen++;
        if (expected_replies.size() == 0) begin
            error_count++;
            if (error_count <= 10)
                $display("ERROR: unexpected result #%0d: status=%0d key=%h id=%h_%h",
                         replies_seen, got.status, got.key, got.high, got.low);
        end else begin
            want = expected_replies.pop_front();
            status_seen[want.status]++;
            if (got.status !== want.status || got.key !== want.key ||
                got.high !== want.high || got.low !== want.low) begin
                error_count++;
                if (error_count <= 10)
                    $display("ERROR: result #%0d expected %0d/%h/%h_%h got %0d/%h/%h_%h",
                             replies_seen, want.status, want.key, want.high, want.low,
                             got.status, got.key, got.high, got.low);
            end
        end
    endtask

    // Result side: check each transaction, then pick the next ready value.
    always @(posedge clk) begin
        if (out_valid && out_ready)
            check_reply();
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end else if (!no_idling && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 8);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    initial begin
        int dead_cycles;
        dead_cycles = 0;
        while (dead_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                dead_cycles = 0;
            else
                dead_cycles++;
        end
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    task automatic test_directed();
        logic [63:0] idh;
        logic [63:0] idl;
        logic [63:0] owner;
        logic [31:0] key;
        // empty table, zero id
        send_item(OP_TAKE, 32'd0, '0, '0, '0, '0);
        send_item(OP_INSERT, 32'd0, '0, '0, '0, '0);
        send_item(OP_INSERT, 32'd0, '1, '1, '1, '1);
        // duplicate id lands in the next slot; takes hit the lowest one first
        send_item(OP_INSERT, 32'd0, '1, '1, 64'h5555_5555_5555_5555, 32'h1234_5678);
        send_item(OP_TAKE, 32'd599, '1, '1, '1, '0);
        send_item(OP_TAKE, 32'd599, '1, '1, '1, '0);
        send_item(OP_TAKE, 32'd599, '1, '1, '1, '0);
        // expiry equal to now counts as expired
        send_item(OP_TAKE, 32'd600, '0, '0, '0, '0);

        // zero lifetime: expired at once, swept by the next insert
        write_lifetime(16'd0);
        idh = rand64();
        idl = rand64();
        owner = rand64();
        send_item(OP_INSERT, 32'd1000, idh, idl, owner, $urandom);
        send_item(OP_TAKE, 32'd1000, idh, idl, owner, '0);
        send_item(OP_INSERT, 32'd2000, idh, idl, owner, $urandom);
        send_item(OP_INSERT, 32'd2000, rand64(), rand64(), rand64(), $urandom);
        send_item(OP_TAKE, 32'd2000, idh, idl, owner, '0);

        // longest lifetime at the top of the time range
        write_lifetime(16'hFFFF);
        idh = rand64();
        idl = rand64();
        owner = rand64();
        key = $urandom;
        send_item(OP_INSERT, 32'hFFFF_FFFF, idh, idl, owner, key);
        send_item(OP_TAKE, 32'hFFFF_FFFF, idh, idl, owner, '0);
        send_item(OP_INSERT, 32'hFFFF_FFFF, idh, idl, owner, key);
        send_item(OP_TAKE, 32'd0, idh, idl, ~owner, '0);
        send_item(OP_INSERT, 32'hFFFF_0000, idh, idl, owner, key);
        send_item(OP_TAKE, 32'hFFFF_FFFF, idh, idl, owner, '0);
    endtask

    task automatic test_full_table();
        int i;
        write_lifetime(16'hFFFF);
        wall_time = $urandom_range(0, 32'h7FFF_FFFF);
        for (i = 0; i < 262; i++)
            send_item(OP_INSERT, wall_time, rand64(), rand64(), rand64(), $urandom);
        for (i = 0; i < 30; i++)
            take_live(wall_time + i, i % 5 == 0, AT_NOW);
        send_item(OP_INSERT, wall_time, rand64(), rand64(), rand64(), $urandom);
        send_item(OP_INSERT, wall_time, rand64(), rand64(), rand64(), $urandom);
        // all entries share one expiry, so this take empties the table
        take_live(wall_time, 1'b0, AT_EXPIRY);
        send_item(OP_INSERT, wall_time, rand64(), rand64(), rand64(), $urandom);
    endtask

    task automatic test_backpressure();
        hold_left = HOLD_CYCLES;
        repeat (6) random_item();
    endtask

    task automatic test_random_mix();
        write_lifetime(16'd1);
        repeat (RANDOM_PER_SETTING) random_item();
        write_lifetime(16'($urandom_range(2, 65534)));
        repeat (RANDOM_PER_SETTING) random_item();
        write_lifetime(16'd9000);
        repeat (RANDOM_PER_SETTING) random_item();
        write_lifetime(16'd45);
        repeat (RANDOM_PER_SETTING) random_item();
    endtask

    task automatic test_steady_stream();
        no_idling = 1'b1;
        write_lifetime(LIFETIME_RESET);
        repeat (60) random_item();
    endtask

    initial begin
        int s;
        lifetime = LIFETIME_RESET;
        for (s = 0; s < SLOTS; s++)
            tbl_valid[s] = 1'b0;
        for (s = 0; s < 5; s++)
            status_seen[s] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_full_table();
        test_backpressure();
        test_random_mix();
        test_steady_stream();
        wait_drained(ITEM_CYCLES);

        $display("Covered %0d inserts and %0d takes over %0d lifetime writes, with a %0d-cycle hold",
                 n_inserts, n_takes, n_cfg, HOLD_CYCLES);
        $display("Outcomes: ok %0d, full %0d, not found %0d, expired %0d, owner mismatch %0d; %0d errors",
                 status_seen[STAT_OK], status_seen[STAT_FULL], status_seen[STAT_NOT_FOUND],
                 status_seen[STAT_EXPIRED], status_seen[STAT_MISMATCH], error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: expiring_one_shot_token_table.f
src/eott_pkg.sv
src/eott_mem.sv
src/eott_ctrl.sv
src/expiring_one_shot_token_table.sv
dv/testbench.sv
